### rtl/aabb_pp_pkg.sv
// Shared types, widths and helpers for the box pair overlap block.
// Used by the pair unit and the top level; depends on nothing else.
package aabb_pp_pkg;

   localparam int MAX_BOXES  = 64;
   localparam int COORD_BITS = 32;

   localparam int ADDR_W  = $clog2(MAX_BOXES);
   localparam int CNT_W   = $clog2(MAX_BOXES + 1);
   localparam int INDEX_W = 6;
   localparam int DEPTH_W = 33;
   localparam int SUM_W   = COORD_BITS + 1;
   localparam int WIDE_W  = COORD_BITS + 2;
   localparam int OV_W    = COORD_BITS + 3;
   localparam int CMP_W   = (OV_W > DEPTH_W) ? OV_W : DEPTH_W;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [OV_W-1:0]   ov_type;

   typedef struct packed {
      logic                         first_of_set;
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] earlier_index;
      logic [INDEX_W-1:0] newer_index;
      logic [1:0]         normal_axis;
      logic               normal_negative;
      logic [DEPTH_W-1:0] depth_doubled;
      logic               last_of_run;
   } rsp_type;

   // A stored box is kept as per-axis span (max - min) and center sum (min + max).
   typedef struct packed {
      sum_type [2:0] span;
      sum_type [2:0] csum;
   } box_prep_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [INDEX_W-1:0] index;
      logic [1:0]         axis;
      logic               negative;
      logic [DEPTH_W-1:0] depth;
   } cand_type;

   // The argument is known to be positive here.
   function automatic logic [DEPTH_W-1:0] depth_sat(input ov_type ov);
      logic [CMP_W-1:0] w;
      w = CMP_W'(ov);
      if (w > CMP_W'(DEPTH_MAX)) begin
         return DEPTH_MAX;
      end
      return DEPTH_W'(w);
   endfunction

endpackage

### rtl/aabb_pp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependency.
module aabb_pp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/aabb_pp_unit.sv
// Pipelined pair test unit: one stored box against the new box per cycle.
// Depends on aabb_pp_pkg.
module aabb_pp_unit
   import aabb_pp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [INDEX_W-1:0] in_index,
   input  box_prep_type       stored,
   input  box_prep_type       fresh,
   output logic               active,
   output cand_type           cand
);

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [INDEX_W-1:0] s1_index_ff, s2_index_ff, s3_index_ff;
   wide_type [2:0]     total_ff, dl_ff;
   wide_type [2:0]     total_in, dl_in;
   ov_type [2:0]       ov_ff, ov_in;
   logic [2:0]         neg2_ff, neg3_ff;
   logic               hit_ff, hit_in;
   ov_type             best01_ff, best01_in, ov2_ff;
   logic [1:0]         axis01_ff, axis01_in;
   logic [2:0]         pos;
   cand_type           cand_ff, cand_in;

   // Stage one: summed spans and center difference (newer minus earlier).
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         total_in[k] = WIDE_W'($signed(stored.span[k])) + WIDE_W'($signed(fresh.span[k]));
         dl_in[k]    = WIDE_W'($signed(fresh.csum[k])) - WIDE_W'($signed(stored.csum[k]));
      end
   end

   // Stage two: doubled overlap = total - |dl|.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dl_ff[k][WIDE_W-1]) begin
            ov_in[k] = OV_W'($signed(total_ff[k])) + OV_W'($signed(dl_ff[k]));
         end else begin
            ov_in[k] = OV_W'($signed(total_ff[k])) - OV_W'($signed(dl_ff[k]));
         end
      end
   end

   // Stage three: overlap test and the x against y choice.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos[k] = !ov_ff[k][OV_W-1] && (ov_ff[k] != '0);
      end
      hit_in = &pos;
      if ($signed(ov_ff[1]) < $signed(ov_ff[0])) begin
         best01_in = ov_ff[1];
         axis01_in = AXIS_Y;
      end else begin
         best01_in = ov_ff[0];
         axis01_in = AXIS_X;
      end
   end

   // Stage four: z against the better of x and y; ties keep the earlier axis.
   always_comb begin
      cand_in.valid = s3_valid_ff;
      cand_in.hit   = hit_ff;
      cand_in.index = s3_index_ff;
      if ($signed(ov2_ff) < $signed(best01_ff)) begin
         cand_in.axis     = AXIS_Z;
         cand_in.negative = neg3_ff[2];
         cand_in.depth    = depth_sat(ov2_ff);
      end else begin
         cand_in.axis     = axis01_ff;
         cand_in.negative = (axis01_ff == AXIS_Y) ? neg3_ff[1] : neg3_ff[0];
         cand_in.depth    = depth_sat(best01_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= in_index;
      total_ff    <= total_in;
      dl_ff       <= dl_in;
      s2_index_ff <= s1_index_ff;
      ov_ff       <= ov_in;
      for (int k = 0; k < 3; k++) begin
         neg2_ff[k] <= dl_ff[k][WIDE_W-1];
      end
      s3_index_ff <= s2_index_ff;
      hit_ff      <= hit_in;
      best01_ff   <= best01_in;
      axis01_ff   <= axis01_in;
      ov2_ff      <= ov_ff[2];
      neg3_ff     <= neg2_ff;
      cand_ff     <= cand_in;
   end

   assign active = s1_valid_ff || s2_valid_ff || s3_valid_ff;

   always_comb begin
      cand       = cand_ff;
      cand.valid = out_valid_ff;
   end

endmodule

### rtl/aabb_pair_penetration.sv
// Top level of the box pair overlap block: sequencer, box memory and pair unit.
// Depends on aabb_pp_pkg, aabb_pp_ram and aabb_pp_unit.
//
// A box is taken when start is high and busy is low. With n boxes already in
// the store, the pair unit then tests the n stored boxes, one per cycle, fed by
// the single read port of the box memory, and drains before busy falls. Each
// overlapping pair comes out as one beat, marked by rsp_valid for a single
// cycle, in ascending order of the stored index; the receiver must take every
// beat as it comes. The final beat caused by a box carries last_of_run and
// arrives in the same cycle as busy falls. A box that yields no overlap, the
// first box of a set, and a box arriving at a full store produce no beat at
// all; a box arriving at a full store does not raise busy.
module aabb_pair_penetration
   import aabb_pp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   eff_count;
   logic               rd_valid_ff;
   logic [INDEX_W-1:0] rd_idx_ff;
   box_prep_type       fresh_ff, fresh_in;
   box_prep_type       stored;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               accept, issue, drained, unit_active;
   cand_type           cand;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign eff_count = req_data.first_of_set ? '0 : count_ff;
   assign issue     = (state_ff == ST_RUN) && (rd_ptr_ff < n_ff);
   assign drained   = !issue && !rd_valid_ff && !unit_active;

   aabb_pp_ram #(
      .WIDTH($bits(box_prep_type)),
      .DEPTH(MAX_BOXES)
   ) u_store (
      .clock  (clock),
      .wr_en  (state_ff == ST_WRITE),
      .wr_addr(n_ff[ADDR_W-1:0]),
      .wr_data(fresh_ff),
      .rd_en  (issue),
      .rd_addr(rd_ptr_ff[ADDR_W-1:0]),
      .rd_data(stored)
   );

   aabb_pp_unit u_unit (
      .clock   (clock),
      .reset   (reset),
      .in_valid(rd_valid_ff),
      .in_index(rd_idx_ff),
      .stored  (stored),
      .fresh   (fresh_ff),
      .active  (unit_active),
      .cand    (cand)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      rd_ptr_in     = rd_ptr_ff;
      fresh_in      = fresh_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = eff_count;
               if (eff_count != CNT_W'(MAX_BOXES)) begin
                  count_in         = eff_count + 1'b1;
                  n_in             = eff_count;
                  rd_ptr_in        = '0;
                  fresh_in.span[0] = SUM_W'(req_data.max_x) - SUM_W'(req_data.min_x);
                  fresh_in.span[1] = SUM_W'(req_data.max_y) - SUM_W'(req_data.min_y);
                  fresh_in.span[2] = SUM_W'(req_data.max_z) - SUM_W'(req_data.min_z);
                  fresh_in.csum[0] = SUM_W'(req_data.max_x) + SUM_W'(req_data.min_x);
                  fresh_in.csum[1] = SUM_W'(req_data.max_y) + SUM_W'(req_data.min_y);
                  fresh_in.csum[2] = SUM_W'(req_data.max_z) + SUM_W'(req_data.min_z);
                  state_in         = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            // A hit is held back in pend until the next hit or the flush, so that the last one can be marked.
            if (cand.valid && cand.hit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pend_ff;
               end
               pend_valid_in           = 1'b1;
               pend_in.earlier_index   = cand.index;
               pend_in.newer_index     = INDEX_W'(n_ff);
               pend_in.normal_axis     = cand.axis;
               pend_in.normal_negative = cand.negative;
               pend_in.depth_doubled   = cand.depth;
               pend_in.last_of_run     = 1'b0;
            end
            if (drained) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = pend_ff;
               rsp_data_in.last_of_run = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         rd_valid_ff   <= issue;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff        <= n_in;
      rd_idx_ff   <= INDEX_W'(rd_ptr_ff);
      fresh_ff    <= fresh_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BOXES))
      else $error("box count above capacity");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> rd_ptr_ff <= n_ff)
      else $error("read pointer ran past the stored boxes");

   a_cand_in_run: assert property (@(posedge clock) disable iff (reset)
      cand.valid |-> state_ff == ST_RUN)
      else $error("pair result outside the scan");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held result left behind at end of scan");

   a_beat_from_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_RUN || state_ff == ST_FLUSH))
      else $error("result beat without a scan");

endmodule

### test/aabb_pair_penetration_tb.sv
// Testbench for aabb_pair_penetration: sends boxes through the command port and
// checks every pair beat against a predictor of the block kept in this file.
// Depends on aabb_pp_pkg and the RTL of the block.
module aabb_pair_penetration_tb;
   import aabb_pp_pkg::*;

   localparam longint ONE_UNIT    = 64'sd65536;
   localparam longint COORD_LO    = -(64'sd1 <<< (COORD_BITS - 1));
   localparam longint COORD_HI    = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam int     IDLE_LIMIT  = 1000;
   localparam int     TAIL_CYCLES = 80;
   localparam int     TOTAL_BOXES = 210;

   typedef enum int {SHAPE_COARSE, SHAPE_FINE, SHAPE_MID} shape_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Predictor state: the boxes the block should hold, as sign-extended corners.
   longint  box_lo [MAX_BOXES][3];
   longint  box_hi [MAX_BOXES][3];
   int      stored_boxes = 0;
   rsp_type expected_pairs [$];

   longint  cluster_base [3];
   bit      steady_sender = 1'b0;
   int      boxes_sent    = 0;
   int      mismatches    = 0;
   int      quiet_cycles  = 0;

   aabb_pair_penetration DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Works out the pair beats that one accepted box causes and stores the box.
   function automatic void predict_pairs(input req_type b);
      longint     nlo [3];
      longint     nhi [3];
      longint     ov [3];
      longint     dl [3];
      longint     best;
      logic [1:0] axis;
      rsp_type    pair;
      bit         any_hit;
      if (b.first_of_set) stored_boxes = 0;
      if (stored_boxes >= MAX_BOXES) return;
      nlo[0] = longint'($signed(b.min_x));
      nlo[1] = longint'($signed(b.min_y));
      nlo[2] = longint'($signed(b.min_z));
      nhi[0] = longint'($signed(b.max_x));
      nhi[1] = longint'($signed(b.max_y));
      nhi[2] = longint'($signed(b.max_z));
      any_hit = 1'b0;
      for (int i = 0; i < stored_boxes; i++) begin
         for (int k = 0; k < 3; k++) begin
            dl[k] = (nlo[k] + nhi[k]) - (box_lo[i][k] + box_hi[i][k]);
            ov[k] = (box_hi[i][k] - box_lo[i][k]) + (nhi[k] - nlo[k])
                    - ((dl[k] < 0) ? -dl[k] : dl[k]);
         end
         if (ov[0] <= 0 || ov[1] <= 0 || ov[2] <= 0) continue;
         axis = AXIS_X;
         best = ov[0];
         if (ov[1] < best) begin
            axis = AXIS_Y;
            best = ov[1];
         end
         if (ov[2] < best) begin
            axis = AXIS_Z;
            best = ov[2];
         end
         pair.earlier_index   = INDEX_W'(i);
         pair.newer_index     = INDEX_W'(stored_boxes);
         pair.normal_axis     = axis;
         pair.normal_negative = (dl[axis] < 0);
         pair.depth_doubled   = (best > longint'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(best);
         pair.last_of_run     = 1'b0;
         expected_pairs.push_back(pair);
         any_hit = 1'b1;
      end
      if (any_hit) expected_pairs[expected_pairs.size() - 1].last_of_run = 1'b1;
      for (int k = 0; k < 3; k++) begin
         box_lo[stored_boxes][k] = nlo[k];
         box_hi[stored_boxes][k] = nhi[k];
      end
      stored_boxes++;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Results are checked before the box accepted at the same edge is predicted.
   always @(posedge clock) begin : pair_checker
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_pairs.size() == 0) begin
               $display("%0t: pair beat with none expected, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_pairs.pop_front();
               check_field("earlier_index", 64'(want.earlier_index),
                           64'(rsp_data.earlier_index));
               check_field("newer_index", 64'(want.newer_index),
                           64'(rsp_data.newer_index));
               check_field("normal_axis", 64'(want.normal_axis),
                           64'(rsp_data.normal_axis));
               check_field("normal_negative", 64'(want.normal_negative),
                           64'(rsp_data.normal_negative));
               check_field("depth_doubled", 64'(want.depth_doubled),
                           64'(rsp_data.depth_doubled));
               check_field("last_of_run", 64'(want.last_of_run),
                           64'(rsp_data.last_of_run));
            end
         end
         if (start && !busy) predict_pairs(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (steady_sender) return 0;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Called at a falling edge; returns at the falling edge after the box is taken.
   task automatic send_box(input req_type b);
      int gap;
      gap = pick_gap();
      repeat (gap) @(negedge clock);
      start    = 1'b1;
      req_data = b;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      boxes_sent++;
   endtask

   task automatic drain_results();
      while (expected_pairs.size() != 0) @(negedge clock);
   endtask

   function automatic req_type make_box(input bit first, input longint lx, ly, lz,
                                        hx, hy, hz);
      req_type b;
      b.first_of_set = first;
      b.min_x = COORD_BITS'(lx);
      b.min_y = COORD_BITS'(ly);
      b.min_z = COORD_BITS'(lz);
      b.max_x = COORD_BITS'(hx);
      b.max_y = COORD_BITS'(hy);
      b.max_z = COORD_BITS'(hz);
      return b;
   endfunction

   task automatic send_units(input bit first, input longint lx, ly, lz, hx, hy, hz);
      send_box(make_box(first, lx * ONE_UNIT, ly * ONE_UNIT, lz * ONE_UNIT,
                        hx * ONE_UNIT, hy * ONE_UNIT, hz * ONE_UNIT));
   endtask

   task automatic pick_cluster();
      for (int k = 0; k < 3; k++) cluster_base[k] = longint'($signed($urandom())) >>> 2;
   endtask

   // A box near the current cluster; offsets and sizes are counted in grains.
   function automatic req_type cluster_box(input bit first, input int unsigned grain,
                                           off_steps, size_lo, size_hi);
      longint lo [3];
      longint hi [3];
      for (int k = 0; k < 3; k++) begin
         lo[k] = cluster_base[k] + longint'($urandom_range(off_steps)) * grain;
         hi[k] = lo[k] + longint'($urandom_range(size_hi, size_lo)) * grain;
      end
      return make_box(first, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   function automatic req_type noise_box(input bit first);
      req_type b;
      b = {first, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return b;
   endfunction

   task automatic test_directed();
      send_units(1, 0, 0, 0, 4, 4, 4);
      send_units(0, 3, 1, 1, 7, 5, 5);      // least overlap on x
      send_units(0, 0, -3, 0, 4, 1, 4);     // least overlap on y, newer center below
      send_units(0, 1, 1, 3, 3, 3, 6);      // least overlap on z
      send_units(0, 0, 0, 0, 4, 4, 4);      // same box: three-way tie, centers equal
      send_units(0, 0, 3, 3, 4, 5, 5);      // y and z tie
      send_units(0, 4, 0, 0, 8, 4, 4);      // touches the first box on x
      send_units(0, 4, 4, 4, 0, 0, 0);      // inverted corners
      send_units(0, 2, 2, 2, 2, 2, 2);      // zero-size box
      send_box(make_box(0, 1, 1, 1, 2, 2, 2));
      // A new set that lands on the old boxes must only see its own members.
      send_units(1, 0, 0, 0, 4, 4, 4);
      send_units(0, 1, 1, 1, 3, 3, 3);
      send_box(make_box(1, COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
      send_box(make_box(0, COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI));
      send_box(make_box(0, 0, 0, 0, 0, 0, 0));
      send_box(make_box(0, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI));
      send_box(make_box(0, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO));
      send_box(make_box(0, COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO));
      send_box(make_box(0, COORD_LO, COORD_LO, 0, -1, COORD_HI, COORD_HI));
      send_box(make_box(0, 1, COORD_LO, COORD_LO, COORD_HI, -1, COORD_HI));
      drain_results();
   endtask

   // Fills the store so the last box meets all the others, then overflows it.
   task automatic test_full_store();
      pick_cluster();
      send_box(cluster_box(1'b1, 1, 65536, 131072, 262144));
      for (int i = 1; i < MAX_BOXES; i++) send_box(cluster_box(1'b0, 1, 65536, 131072, 262144));
      drain_results();
      repeat (3) send_box(cluster_box(1'b0, 1, 65536, 131072, 262144));
      send_box(noise_box(1'b0));
      drain_results();
      send_box(cluster_box(1'b1, 1, 65536, 131072, 262144));
      send_box(cluster_box(1'b0, 1, 65536, 131072, 262144));
   endtask

   // Mostly well-formed sets around one cluster, with stray boxes and early clears.
   task automatic test_random_sets();
      int        set_len;
      int        roll;
      shape_type shape;
      while (boxes_sent < TOTAL_BOXES) begin
         pick_cluster();
         steady_sender = ($urandom_range(4) == 0);
         set_len = ($urandom_range(4) == 0) ? $urandom_range(30, 11) : $urandom_range(10, 2);
         shape = shape_type'($urandom_range(2));
         for (int i = 0; i < set_len; i++) begin
            roll = $urandom_range(99);
            if (roll < 6) send_box(noise_box(1'b0));
            else if (roll < 9) send_box(noise_box(i == 0 || $urandom_range(1) == 1));
            else begin
               case (shape)
                  SHAPE_COARSE: send_box(cluster_box(i == 0, 65536, 4, 1, 3));
                  SHAPE_FINE:   send_box(cluster_box(i == 0, 1, 1 << 20, 0, 1 << 20));
                  default:      send_box(cluster_box(i == 0, 1 << 12, 64, 1, 96));
               endcase
            end
         end
         if ($urandom_range(9) == 0) drain_results();
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_store();
      test_random_sets();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
